FILE: sv/pwmenc_pkg.sv
// Shared constants, register codes and controller/datapath link types.
`timescale 1ns / 1ps
`default_nettype none

package pwmenc_pkg;

  // Default widths for the top-level parameters
  localparam int ANGLE_BITS_DEF   = 14;
  localparam int CAPTURE_BITS_DEF = 16;
  localparam int ADC_BITS_DEF     = 12;

  // Decoder constants: frame length in clocks and the leading pre-count
  localparam int FRAME_COUNT = 4119;
  localparam int FRAME_W     = 13;
  localparam int PRE_COUNT   = 12 + 4;

  // Field widths fixed by the register map and result format
  localparam int GAIN_W     = 24;
  localparam int OFFSET_W   = 15;
  localparam int ELEC_W     = 24;
  localparam int TURN_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Electrical angle scaling: Q8.16 gain, angle counts to 1/256 degree
  localparam int FRAC_SHIFT   = 16;
  localparam int ROUND_HALF   = 32768;
  localparam int QUARTER_TURN = 23040;
  localparam int ELEC_MAX     = 8388607;
  localparam int ELEC_MIN     = -8388608;

  // Register reset values
  localparam int GAIN_RST     = 368640;
  localparam int OFFSET_U_RST = 2525;
  localparam int OFFSET_V_RST = 2513;
  localparam int OFFSET_W_RST = 2530;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEC_GAIN   = 3'd0,
    REG_ELEC_OFFSET = 3'd1,
    REG_ELEC_DIR    = 3'd2,
    REG_OFFSET_U    = 3'd3,
    REG_OFFSET_V    = 3'd4,
    REG_OFFSET_W    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_step;
    logic angle_upd;
    logic turn_upd;
    logic e_shift;
    logic e_sat;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic do_div;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/pwmenc_if.sv
// Channel interfaces: input tick, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface pwmenc_in_if #(
  parameter int CAPTURE_BITS = pwmenc_pkg::CAPTURE_BITS_DEF,
  parameter int ADC_BITS     = pwmenc_pkg::ADC_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    cap_edge;
  logic [CAPTURE_BITS-1:0] period_count;
  logic [CAPTURE_BITS-1:0] high_count;
  logic [ADC_BITS-1:0]     adc_u;
  logic [ADC_BITS-1:0]     adc_v;
  logic [ADC_BITS-1:0]     adc_w;

  modport source (output valid, cap_edge, period_count, high_count, adc_u, adc_v, adc_w,
                  input ready);
  modport sink (input valid, cap_edge, period_count, high_count, adc_u, adc_v, adc_w,
                output ready);
endinterface

interface pwmenc_out_if #(
  parameter int ANGLE_BITS = pwmenc_pkg::ANGLE_BITS_DEF,
  parameter int ADC_BITS   = pwmenc_pkg::ADC_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic [ANGLE_BITS-1:0]                 mech_angle;
  logic signed [pwmenc_pkg::TURN_W-1:0]  turn_count;
  logic signed [pwmenc_pkg::ELEC_W-1:0]  elec_angle;
  logic signed [ADC_BITS:0]              current_u;
  logic signed [ADC_BITS:0]              current_v;
  logic signed [ADC_BITS:0]              current_w;
  logic                                  decode_error;

  modport source (output valid, mech_angle, turn_count, elec_angle, current_u, current_v,
                  current_w, decode_error, input ready);
  modport sink (input valid, mech_angle, turn_count, elec_angle, current_u, current_v,
                current_w, decode_error, output ready);
endinterface

interface pwmenc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pwmenc_pkg::CFG_IDX_W-1:0]    index;
  logic [pwmenc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/pwmenc_cfg.sv
// Configuration register file for gain, offset, direction and ADC zero codes.
`timescale 1ns / 1ps
`default_nettype none

module pwmenc_cfg #(
  parameter int ADC_BITS = pwmenc_pkg::ADC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  wr_valid,
  output logic                                       wr_ready,
  input  wire logic [pwmenc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire logic [pwmenc_pkg::CFG_DATA_W-1:0]     wr_data,
  output logic [pwmenc_pkg::GAIN_W-1:0]              elec_gain,
  output logic signed [pwmenc_pkg::OFFSET_W-1:0]     elec_offset,
  output logic                                       elec_dir_negative,
  output logic [ADC_BITS-1:0]                        offset_u,
  output logic [ADC_BITS-1:0]                        offset_v,
  output logic [ADC_BITS-1:0]                        offset_w
);

  logic [pwmenc_pkg::GAIN_W-1:0]          gain_r;
  logic signed [pwmenc_pkg::OFFSET_W-1:0] eoff_r;
  logic                                   dir_r;
  logic [ADC_BITS-1:0]                    off_u_r;
  logic [ADC_BITS-1:0]                    off_v_r;
  logic [ADC_BITS-1:0]                    off_w_r;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= pwmenc_pkg::GAIN_W'(pwmenc_pkg::GAIN_RST);
      eoff_r  <= '0;
      dir_r   <= 1'b0;
      off_u_r <= ADC_BITS'(pwmenc_pkg::OFFSET_U_RST);
      off_v_r <= ADC_BITS'(pwmenc_pkg::OFFSET_V_RST);
      off_w_r <= ADC_BITS'(pwmenc_pkg::OFFSET_W_RST);
    end else if (wr_valid) begin
      case (wr_index)
        pwmenc_pkg::REG_ELEC_GAIN:   gain_r  <= wr_data[pwmenc_pkg::GAIN_W-1:0];
        pwmenc_pkg::REG_ELEC_OFFSET: eoff_r  <= $signed(wr_data[pwmenc_pkg::OFFSET_W-1:0]);
        pwmenc_pkg::REG_ELEC_DIR:    dir_r   <= wr_data[0];
        pwmenc_pkg::REG_OFFSET_U:    off_u_r <= wr_data[ADC_BITS-1:0];
        pwmenc_pkg::REG_OFFSET_V:    off_v_r <= wr_data[ADC_BITS-1:0];
        pwmenc_pkg::REG_OFFSET_W:    off_w_r <= wr_data[ADC_BITS-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  assign elec_gain         = gain_r;
  assign elec_offset       = eoff_r;
  assign elec_dir_negative = dir_r;
  assign offset_u          = off_u_r;
  assign offset_v          = off_v_r;
  assign offset_w          = off_w_r;

endmodule

`default_nettype wire

FILE: sv/pwmenc_ctrl.sv
// Sequencer that steps the datapath through divide, unwrap and scaling.
`timescale 1ns / 1ps
`default_nettype none

module pwmenc_ctrl #(
  parameter int CAPTURE_BITS = pwmenc_pkg::CAPTURE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pwmenc_pkg::status_t sts,
  output pwmenc_pkg::cmd_t         cmd
);

  localparam int NUM_W = CAPTURE_BITS + pwmenc_pkg::FRAME_W;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_ANGLE = 8'b0000_1000,
    S_TURN  = 8'b0001_0000,
    S_ESH   = 8'b0010_0000,
    S_ESAT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.do_div ? S_DIV : S_ANGLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_ANGLE;
        end
      end
      S_ANGLE: begin
        cmd.angle_upd = 1'b1;
        state_nxt     = S_TURN;
      end
      S_TURN: begin
        cmd.turn_upd = 1'b1;
        state_nxt    = S_ESH;
      end
      S_ESH: begin
        cmd.e_shift = 1'b1;
        state_nxt   = S_ESAT;
      end
      S_ESAT: begin
        cmd.e_sat = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pwmenc_dp.sv
// Datapath: serial divider, angle/turn state, electrical scaling, currents.
`timescale 1ns / 1ps
`default_nettype none

module pwmenc_dp #(
  parameter int ANGLE_BITS   = pwmenc_pkg::ANGLE_BITS_DEF,
  parameter int CAPTURE_BITS = pwmenc_pkg::CAPTURE_BITS_DEF,
  parameter int ADC_BITS     = pwmenc_pkg::ADC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire pwmenc_pkg::cmd_t                      cmd,
  output pwmenc_pkg::status_t                        sts,
  input  wire logic                                  cap_edge,
  input  wire logic [CAPTURE_BITS-1:0]               period_count,
  input  wire logic [CAPTURE_BITS-1:0]               high_count,
  input  wire logic [ADC_BITS-1:0]                   adc_u,
  input  wire logic [ADC_BITS-1:0]                   adc_v,
  input  wire logic [ADC_BITS-1:0]                   adc_w,
  input  wire logic [pwmenc_pkg::GAIN_W-1:0]         elec_gain,
  input  wire logic signed [pwmenc_pkg::OFFSET_W-1:0] elec_offset,
  input  wire logic                                  elec_dir_negative,
  input  wire logic [ADC_BITS-1:0]                   offset_u,
  input  wire logic [ADC_BITS-1:0]                   offset_v,
  input  wire logic [ADC_BITS-1:0]                   offset_w,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [ANGLE_BITS-1:0]                      mech_angle,
  output logic signed [pwmenc_pkg::TURN_W-1:0]       turn_count,
  output logic signed [pwmenc_pkg::ELEC_W-1:0]       elec_angle,
  output logic signed [ADC_BITS:0]                   current_u,
  output logic signed [ADC_BITS:0]                   current_v,
  output logic signed [ADC_BITS:0]                   current_w,
  output logic                                       decode_error
);

  localparam int NUM_W   = CAPTURE_BITS + pwmenc_pkg::FRAME_W;
  localparam int DELTA_W = ANGLE_BITS + 2;
  localparam int DIFF_W  = ((ANGLE_BITS > pwmenc_pkg::OFFSET_W) ?
                            ANGLE_BITS : pwmenc_pkg::OFFSET_W) + 2;
  localparam int PROD_W  = DIFF_W + pwmenc_pkg::GAIN_W + 1;
  localparam int E1_W    = PROD_W - pwmenc_pkg::FRAC_SHIFT + 1;
  localparam int TW      = pwmenc_pkg::TURN_W;
  localparam int EW      = pwmenc_pkg::ELEC_W;

  localparam logic signed [DELTA_W-1:0] HALF = DELTA_W'((1 << (ANGLE_BITS - 1)) - 1);
  localparam logic signed [DELTA_W-1:0] FULL = DELTA_W'(1 << ANGLE_BITS);

  // latched input beat
  logic                    cap_r;
  logic [CAPTURE_BITS-1:0] period_r;
  logic [CAPTURE_BITS-1:0] high_r;
  logic [ADC_BITS-1:0]     adc_u_r, adc_v_r, adc_w_r;

  // divider
  logic [NUM_W-1:0]        q_r;
  logic [CAPTURE_BITS-1:0] rem_r;
  logic [CAPTURE_BITS:0]   trial;
  logic                    fits;

  // angle and turn state
  logic [ANGLE_BITS-1:0]   angle_r, prev_r;
  logic [TW-1:0]           turn_r;
  logic                    err_r;
  logic [NUM_W-1:0]        q_sub;
  logic signed [DELTA_W-1:0] delta, delta_adj;

  // electrical angle
  logic signed [DIFF_W-1:0]               diff;
  logic signed [pwmenc_pkg::GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]               prod, prod_r, rounded;
  logic signed [E1_W-1:0]                 e1, e1_r;
  logic signed [E1_W:0]                   e2;
  logic signed [EW-1:0]                   elec_nxt, elec_r;

  // output register
  logic                    out_valid_r;
  logic [ANGLE_BITS-1:0]   mech_r;
  logic [TW-1:0]           turn_out_r;
  logic signed [EW-1:0]    elec_out_r;
  logic signed [ADC_BITS:0] cur_u_r, cur_v_r, cur_w_r;
  logic                    err_out_r;

  assign sts.do_div   = cap_r && (period_r != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    trial = {rem_r, q_r[NUM_W-1]};
    fits  = (trial >= {1'b0, period_r});
  end

  assign q_sub = q_r - NUM_W'(pwmenc_pkg::PRE_COUNT);

  always_comb begin
    delta = $signed({2'b00, angle_r}) - $signed({2'b00, prev_r});
    if (delta > HALF) begin
      delta_adj = delta - FULL;
    end else if (delta < -HALF) begin
      delta_adj = delta + FULL;
    end else begin
      delta_adj = delta;
    end
  end

  always_comb begin
    diff    = $signed({{(DIFF_W - ANGLE_BITS){1'b0}}, angle_r}) - DIFF_W'(elec_offset);
    gain_s  = $signed({1'b0, elec_gain});
    prod    = diff * gain_s;
    rounded = prod_r + PROD_W'(pwmenc_pkg::ROUND_HALF);
    e1      = E1_W'(rounded >>> pwmenc_pkg::FRAC_SHIFT) - E1_W'(pwmenc_pkg::QUARTER_TURN);
    e2      = elec_dir_negative ? -((E1_W+1)'(e1_r)) : (E1_W+1)'(e1_r);
    if (e2 > (E1_W+1)'(pwmenc_pkg::ELEC_MAX)) begin
      elec_nxt = EW'(pwmenc_pkg::ELEC_MAX);
    end else if (e2 < (E1_W+1)'(pwmenc_pkg::ELEC_MIN)) begin
      elec_nxt = EW'(pwmenc_pkg::ELEC_MIN);
    end else begin
      elec_nxt = e2[EW-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cap_r    <= cap_edge;
      period_r <= period_count;
      high_r   <= high_count;
      adc_u_r  <= adc_u;
      adc_v_r  <= adc_v;
      adc_w_r  <= adc_w;
    end
    if (cmd.mul) begin
      q_r   <= NUM_W'(high_r) * NUM_W'(pwmenc_pkg::FRAME_COUNT);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= {q_r[NUM_W-2:0], fits};
      rem_r <= fits ? CAPTURE_BITS'(trial - {1'b0, period_r}) : trial[CAPTURE_BITS-1:0];
    end
    if (cmd.angle_upd) begin
      err_r <= cap_r && ((period_r == '0) || (q_r < NUM_W'(pwmenc_pkg::PRE_COUNT)));
    end
    if (cmd.turn_upd) begin
      prod_r <= prod;
    end
    if (cmd.e_shift) begin
      e1_r <= e1;
    end
    if (cmd.e_sat) begin
      elec_r <= elec_nxt;
    end
    if (cmd.load_out) begin
      mech_r     <= angle_r;
      turn_out_r <= turn_r;
      elec_out_r <= elec_r;
      cur_u_r    <= $signed({1'b0, adc_u_r}) - $signed({1'b0, offset_u});
      cur_v_r    <= $signed({1'b0, adc_v_r}) - $signed({1'b0, offset_v});
      cur_w_r    <= $signed({1'b0, adc_w_r}) - $signed({1'b0, offset_w});
      err_out_r  <= err_r;
    end
  end

  // rotor state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= '0;
      prev_r      <= '0;
      turn_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.angle_upd && sts.do_div && (q_r >= NUM_W'(pwmenc_pkg::PRE_COUNT))) begin
        angle_r <= {q_sub[ANGLE_BITS-3:0], 2'b00};
      end
      if (cmd.turn_upd) begin
        prev_r <= angle_r;
        turn_r <= turn_r - TW'(delta_adj);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign mech_angle   = mech_r;
  assign turn_count   = $signed(turn_out_r);
  assign elec_angle   = elec_out_r;
  assign current_u    = cur_u_r;
  assign current_v    = cur_v_r;
  assign current_w    = cur_w_r;
  assign decode_error = err_out_r;

endmodule

`default_nettype wire

FILE: sv/pwm_encoder_angle_current_sense.sv
// Top level: PWM absolute encoder decode, multi-turn unwrap, current offsets.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | cap_edge, period_count, high_count, adc_u/v/w
//  out_ch   | out | mech_angle, turn_count, elec_angle, current_u/v/w, error
//  cfg_ch   | in  | index (register number), data (value, low bits used)
//
// A tick with a valid capture (cap_edge set, nonzero period) runs through the
// restoring divider, which retires one quotient bit a cycle over
// CAPTURE_BITS+13 bits; a tick without one skips the divide.
// rst_n is synchronous; it clears the angle, turn count and config registers.
// A finished result sits in the output register, so a stalled sink does not
// block the next accept; the sequencer only waits to reload that register.
`timescale 1ns / 1ps
`default_nettype none

module pwm_encoder_angle_current_sense #(
  parameter int ANGLE_BITS   = pwmenc_pkg::ANGLE_BITS_DEF,
  parameter int CAPTURE_BITS = pwmenc_pkg::CAPTURE_BITS_DEF,
  parameter int ADC_BITS     = pwmenc_pkg::ADC_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  pwmenc_in_if.sink   in_ch,
  pwmenc_out_if.source out_ch,
  pwmenc_cfg_if.sink  cfg_ch
);

  pwmenc_pkg::cmd_t    cmd;
  pwmenc_pkg::status_t sts;

  logic [pwmenc_pkg::GAIN_W-1:0]          elec_gain;
  logic signed [pwmenc_pkg::OFFSET_W-1:0] elec_offset;
  logic                                   elec_dir_negative;
  logic [ADC_BITS-1:0]                    offset_u, offset_v, offset_w;

  // configuration: always ready, writes land the next edge
  pwmenc_cfg #(
    .ADC_BITS (ADC_BITS)
  ) u_cfg (
    .clk               (clk),
    .rst_n             (rst_n),
    .wr_valid          (cfg_ch.valid),
    .wr_ready          (cfg_ch.ready),
    .wr_index          (cfg_ch.index),
    .wr_data           (cfg_ch.data),
    .elec_gain         (elec_gain),
    .elec_offset       (elec_offset),
    .elec_dir_negative (elec_dir_negative),
    .offset_u          (offset_u),
    .offset_v          (offset_v),
    .offset_w          (offset_w)
  );

  // sequencer owns the input handshake and the divide iteration count
  pwmenc_ctrl #(
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds the rotor state and the output register
  pwmenc_dp #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CAPTURE_BITS (CAPTURE_BITS),
    .ADC_BITS     (ADC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cap_edge          (in_ch.cap_edge),
    .period_count      (in_ch.period_count),
    .high_count        (in_ch.high_count),
    .adc_u             (in_ch.adc_u),
    .adc_v             (in_ch.adc_v),
    .adc_w             (in_ch.adc_w),
    .elec_gain         (elec_gain),
    .elec_offset       (elec_offset),
    .elec_dir_negative (elec_dir_negative),
    .offset_u          (offset_u),
    .offset_v          (offset_v),
    .offset_w          (offset_w),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .mech_angle        (out_ch.mech_angle),
    .turn_count        (out_ch.turn_count),
    .elec_angle        (out_ch.elec_angle),
    .current_u         (out_ch.current_u),
    .current_v         (out_ch.current_v),
    .current_w         (out_ch.current_w),
    .decode_error      (out_ch.decode_error)
  );

endmodule

`default_nettype wire

FILE: sv/pwmenc_chk.sv
// Port-level checker for the encoder block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pwmenc_chk #(
  parameter int ANGLE_BITS = pwmenc_pkg::ANGLE_BITS_DEF,
  parameter int ADC_BITS   = pwmenc_pkg::ADC_BITS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [ANGLE_BITS-1:0]              mech_angle,
  input wire logic [pwmenc_pkg::TURN_W-1:0]      turn_count,
  input wire logic [pwmenc_pkg::ELEC_W-1:0]      elec_angle,
  input wire logic [ADC_BITS:0]                  current_u
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one beat in flight: accept closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a new result only appears while a beat is being worked on
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised with no beat in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(mech_angle) && $stable(turn_count) &&
                                   $stable(elec_angle) && $stable(current_u)))
    else $error("result changed while stalled");

endmodule

bind pwm_encoder_angle_current_sense pwmenc_chk #(
  .ANGLE_BITS (ANGLE_BITS),
  .ADC_BITS   (ADC_BITS)
) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .mech_angle (out_ch.mech_angle),
  .turn_count (out_ch.turn_count),
  .elec_angle (out_ch.elec_angle),
  .current_u  (out_ch.current_u)
);

`default_nettype wire

FILE: tb/tb_pwm_encoder_angle_current_sense.sv
// Self-checking bench for the PWM encoder decoder: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module tb_pwm_encoder_angle_current_sense;
  import pwmenc_pkg::*;

  localparam int     AW          = ANGLE_BITS_DEF;
  localparam int     CW          = CAPTURE_BITS_DEF;
  localparam int     DW          = ADC_BITS_DEF;
  // Unwrap window: a change of half a turn or more is taken the other way round
  localparam longint HALF_TURN   = (longint'(1) << (AW - 1)) - 1;
  localparam longint FULL_TURN   = longint'(1) << AW;
  localparam int     HOLD_CYCLES = 400;
  localparam int     DRAIN_WAIT  = 60;

  typedef struct {
    logic          cap;
    logic [CW-1:0] period;
    logic [CW-1:0] high;
    logic [DW-1:0] adc_u;
    logic [DW-1:0] adc_v;
    logic [DW-1:0] adc_w;
  } tick_t;

  typedef struct {
    logic [AW-1:0]     mech;
    logic [TURN_W-1:0] turns;
    logic [ELEC_W-1:0] elec;
    logic [DW:0]       cur_u;
    logic [DW:0]       cur_v;
    logic [DW:0]       cur_w;
    logic              err;
  } sense_t;

  typedef struct {
    logic [GAIN_W-1:0]          gain;
    logic signed [OFFSET_W-1:0] zero_pos;
    logic                       negate;
    logic [DW-1:0]              off_u;
    logic [DW-1:0]              off_v;
    logic [DW-1:0]              off_w;
  } reg_set_t;

  logic clk = 1'b0;
  logic rst_n;

  pwmenc_in_if  in_ch ();
  pwmenc_out_if out_ch ();
  pwmenc_cfg_if cfg_ch ();

  pwm_encoder_angle_current_sense dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the block state and its register file
  logic [AW-1:0]              mech_q;
  logic [AW-1:0]              prev_mech_q;
  logic [TURN_W-1:0]          turns_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [OFFSET_W-1:0] zero_pos_q;
  logic                       negate_q;
  logic [DW-1:0]              off_u_q;
  logic [DW-1:0]              off_v_q;
  logic [DW-1:0]              off_w_q;

  // Results still owed by the block, oldest first
  sense_t pending_sense[$];

  int unsigned fail_count;
  int unsigned ticks_sent;
  int unsigned captures_sent;
  int unsigned bad_decodes;
  int unsigned settings_used;
  int unsigned beats_checked;

  // Knobs shared between the stimulus and the receiver
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned hold_token;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic logic [DW:0] current_of(logic [DW-1:0] sample, logic [DW-1:0] zero);
    int diff;
    diff = int'(sample) - int'(zero);
    return diff[DW:0];
  endfunction

  // Advance the predictor by one tick and return the result it owes
  function automatic sense_t decode_tick(tick_t t);
    sense_t      r;
    logic [63:0] quot;
    longint      turn_delta;
    longint      prod;
    longint      ang;
    r.err = 1'b0;
    if (t.cap) begin
      if (t.period == '0) begin
        r.err = 1'b1;
      end else begin
        quot = (64'(t.high) * 64'(FRAME_COUNT)) / 64'(t.period);
        if (quot < 64'(PRE_COUNT)) begin
          r.err = 1'b1;
        end else begin
          mech_q = AW'((quot - 64'(PRE_COUNT)) << 2);
        end
      end
    end
    // Unwrap the change and count it against the turn total (reversed sense)
    turn_delta = longint'(mech_q) - longint'(prev_mech_q);
    if (turn_delta > HALF_TURN) begin
      turn_delta -= FULL_TURN;
    end else if (turn_delta < -HALF_TURN) begin
      turn_delta += FULL_TURN;
    end
    prev_mech_q = mech_q;
    turns_q     = turns_q - turn_delta[TURN_W-1:0];
    // Q8.16 gain, angle counts to 1/256 degree, round half up, then drop a quarter turn
    prod = (longint'(mech_q) - longint'(zero_pos_q)) * longint'(gain_q) + longint'(ROUND_HALF);
    ang  = (prod >>> FRAC_SHIFT) - longint'(QUARTER_TURN);
    if (negate_q) ang = -ang;
    if (ang > longint'(ELEC_MAX)) ang = longint'(ELEC_MAX);
    if (ang < longint'(ELEC_MIN)) ang = longint'(ELEC_MIN);
    r.mech  = mech_q;
    r.turns = turns_q;
    r.elec  = ang[ELEC_W-1:0];
    r.cur_u = current_of(t.adc_u, off_u_q);
    r.cur_v = current_of(t.adc_v, off_v_q);
    r.cur_w = current_of(t.adc_w, off_w_q);
    return r;
  endfunction

  function automatic tick_t make_tick(logic cap, logic [CW-1:0] period, logic [CW-1:0] high,
                                      logic [DW-1:0] u, logic [DW-1:0] v, logic [DW-1:0] w);
    tick_t t;
    t.cap    = cap;
    t.period = period;
    t.high   = high;
    t.adc_u  = u;
    t.adc_v  = v;
    t.adc_w  = w;
    return t;
  endfunction

  // Mostly clean captures with a plausible duty; the rest is noise and failures
  function automatic tick_t rand_tick();
    tick_t       t;
    int unsigned mode;
    mode     = $urandom_range(0, 99);
    t.cap    = 1'b1;
    t.period = CW'($urandom);
    t.high   = CW'($urandom);
    t.adc_u  = DW'($urandom);
    t.adc_v  = DW'($urandom);
    t.adc_w  = DW'($urandom);
    if (mode < 10) begin
      t.cap = 1'b0;
    end else if (mode < 14) begin
      t.period = '0;
    end else if (mode < 20) begin
      t.high = CW'($urandom_range(0, 40));
    end else if (mode < 24) begin
      t.period = CW'($urandom_range(1, 64));
    end else if (mode < 30) begin
      // leave both counts fully random: high often beyond the period
    end else begin
      t.period = CW'($urandom_range(1, (1 << CW) - 1));
      t.high   = CW'($urandom_range(0, 32'(t.period)));
    end
    return t;
  endfunction

  function automatic reg_set_t reset_regs();
    reg_set_t s;
    s.gain     = GAIN_W'(GAIN_RST);
    s.zero_pos = '0;
    s.negate   = 1'b0;
    s.off_u    = DW'(OFFSET_U_RST);
    s.off_v    = DW'(OFFSET_V_RST);
    s.off_w    = DW'(OFFSET_W_RST);
    return s;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    fail_count++;
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endfunction

  // Offer one tick, hold it until accepted, then book its result
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    sense_t      owed;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cap_edge     <= t.cap;
    in_ch.period_count <= t.period;
    in_ch.high_count   <= t.high;
    in_ch.adc_u        <= t.adc_u;
    in_ch.adc_v        <= t.adc_v;
    in_ch.adc_w        <= t.adc_w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    owed = decode_tick(t);
    pending_sense.push_back(owed);
    ticks_sent++;
    if (t.cap) captures_sent++;
    if (owed.err) bad_decodes++;
  endtask

  // Drive a capture whose quotient is exactly q
  task automatic send_quotient(input int q);
    send_tick(make_tick(1'b1, CW'(FRAME_COUNT), CW'(q),
                        DW'($urandom), DW'($urandom), DW'($urandom)));
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_sense.size() != 0);
  endtask

  // Write the whole register file, one beat per register, block idle
  task automatic apply_settings(input reg_set_t s);
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] wdata;
    idx = idx.first();
    repeat (idx.num()) begin
      wdata = '0;
      case (idx)
        REG_ELEC_GAIN: begin
          wdata  = s.gain;
          gain_q = s.gain;
        end
        REG_ELEC_OFFSET: begin
          wdata[OFFSET_W-1:0] = s.zero_pos;
          zero_pos_q          = s.zero_pos;
        end
        REG_ELEC_DIR: begin
          wdata[0] = s.negate;
          negate_q = s.negate;
        end
        REG_OFFSET_U: begin
          wdata[DW-1:0] = s.off_u;
          off_u_q       = s.off_u;
        end
        REG_OFFSET_V: begin
          wdata[DW-1:0] = s.off_v;
          off_v_q       = s.off_v;
        end
        REG_OFFSET_W: begin
          wdata[DW-1:0] = s.off_w;
          off_w_q       = s.off_w;
        end
        default: ;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= wdata;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      idx = idx.next();
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Random ticks; open with a burst at full rate on both sides, then idle at random
  task automatic run_random(input int unsigned n);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 5) begin
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
      end
      send_tick(rand_tick());
      // now and then pause the sender until the block has caught up
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Decode corners and the unwrap boundaries, reset register values
  task automatic test_directed_decode();
    send_tick(make_tick(1'b0, '1, '1, '0, '0, '0));
    send_tick(make_tick(1'b0, '0, '0, '1, '1, '1));
    // zero period flags an error and holds the angle
    send_tick(make_tick(1'b1, '0, '1, 12'h0F0, 12'h00F, 12'hF00));
    send_quotient(0);
    send_quotient(PRE_COUNT - 1);
    send_quotient(PRE_COUNT);
    send_quotient(PRE_COUNT + 1);
    // just inside the half-turn window, both ways
    send_quotient(PRE_COUNT + 2047);
    send_quotient(PRE_COUNT);
    // exactly half a turn: unwraps to the other side, both ways
    send_quotient(PRE_COUNT + 2048);
    send_quotient(PRE_COUNT);
    // almost a full turn: short way round across zero
    send_quotient(PRE_COUNT + 4095);
    send_quotient(PRE_COUNT);
    // high time far above the period: shifted quotient wraps mod one turn
    send_tick(make_tick(1'b1, CW'(1), '1, '1, '0, '1));
    send_tick(make_tick(1'b1, '1, '1, '0, '1, '0));
    send_tick(make_tick(1'b1, '1, CW'(254), DW'($urandom), DW'($urandom), DW'($urandom)));
    send_tick(make_tick(1'b1, '1, CW'(255), DW'($urandom), DW'($urandom), DW'($urandom)));
    send_tick(make_tick(1'b1, CW'(1), CW'(1), DW'($urandom), DW'($urandom), DW'($urandom)));
    send_tick(make_tick(1'b1, CW'(1000), CW'(1001),
                        DW'($urandom), DW'($urandom), DW'($urandom)));
    // no capture: counts are ignored, angle holds
    send_tick(make_tick(1'b0, CW'(1), '1, DW'($urandom), DW'($urandom), DW'($urandom)));
    wait_drained();
  endtask

  // Both ends of every register
  task automatic test_extreme_settings();
    reg_set_t s;
    s.gain     = '0;
    s.zero_pos = {1'b1, {(OFFSET_W - 1){1'b0}}};
    s.negate   = 1'b1;
    s.off_u    = '0;
    s.off_v    = '0;
    s.off_w    = '0;
    apply_settings(s);
    run_random(150);
    wait_drained();
    s.gain     = '1;
    s.zero_pos = {1'b0, {(OFFSET_W - 1){1'b1}}};
    s.negate   = 1'b0;
    s.off_u    = '1;
    s.off_v    = '1;
    s.off_w    = '1;
    apply_settings(s);
    run_random(150);
    wait_drained();
  endtask

  // Stall the receiver for a long stretch while the sender keeps pushing
  task automatic test_output_hold();
    src_idle_en = 1'b0;
    hold_token++;
    repeat (40) send_tick(rand_tick());
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  task automatic test_random_settings();
    reg_set_t s;
    repeat (4) begin
      s.gain     = GAIN_W'($urandom);
      s.zero_pos = OFFSET_W'($urandom);
      s.negate   = 1'($urandom);
      s.off_u    = DW'($urandom);
      s.off_v    = DW'($urandom);
      s.off_w    = DW'($urandom);
      apply_settings(s);
      run_random(200);
      wait_drained();
    end
  endtask

  task automatic test_reset_values_again();
    apply_settings(reset_regs());
    run_random(150);
    wait_drained();
  endtask

  // Receiver: ready with random stalls; a hold request holds it low a long while
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned hold_seen;
    wait_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        wait_left = HOLD_CYCLES;
      end
      if (wait_left > 0) begin
        out_ch.ready <= 1'b0;
        wait_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_idle_en) wait_left = pick_gap();
      end
    end
  end

  // Check every result beat against the oldest owed result
  always @(posedge clk) begin : result_check
    sense_t got;
    sense_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.mech  = out_ch.mech_angle;
      got.turns = out_ch.turn_count;
      got.elec  = out_ch.elec_angle;
      got.cur_u = out_ch.current_u;
      got.cur_v = out_ch.current_v;
      got.cur_w = out_ch.current_w;
      got.err   = out_ch.decode_error;
      if (pending_sense.size() == 0) begin
        fail_count++;
        $display("%0t ns: result beat with nothing owed, mech_angle 0x%0h", $time, got.mech);
      end else begin
        want = pending_sense.pop_front();
        beats_checked++;
        if (got.mech !== want.mech)
          note_mismatch("mech_angle", 32'(want.mech), 32'(got.mech));
        if (got.turns !== want.turns)
          note_mismatch("turn_count", want.turns, got.turns);
        if (got.elec !== want.elec)
          note_mismatch("elec_angle", 32'(want.elec), 32'(got.elec));
        if (got.cur_u !== want.cur_u)
          note_mismatch("current_u", 32'(want.cur_u), 32'(got.cur_u));
        if (got.cur_v !== want.cur_v)
          note_mismatch("current_v", 32'(want.cur_v), 32'(got.cur_v));
        if (got.cur_w !== want.cur_w)
          note_mismatch("current_w", 32'(want.cur_w), 32'(got.cur_w));
        if (got.err !== want.err)
          note_mismatch("decode_error", 32'(want.err), 32'(got.err));
      end
    end
  end

  initial begin
    // Known values on every input from time zero
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cap_edge     <= 1'b0;
    in_ch.period_count <= '0;
    in_ch.high_count   <= '0;
    in_ch.adc_u        <= '0;
    in_ch.adc_v        <= '0;
    in_ch.adc_w        <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_ELEC_GAIN;
    cfg_ch.data        <= '0;

    // Predictor starts from the reset state
    mech_q        = '0;
    prev_mech_q   = '0;
    turns_q       = '0;
    gain_q        = GAIN_W'(GAIN_RST);
    zero_pos_q    = '0;
    negate_q      = 1'b0;
    off_u_q       = DW'(OFFSET_U_RST);
    off_v_q       = DW'(OFFSET_V_RST);
    off_w_q       = DW'(OFFSET_W_RST);
    fail_count    = 0;
    ticks_sent    = 0;
    captures_sent = 0;
    bad_decodes   = 0;
    settings_used = 0;
    beats_checked = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    hold_token    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_decode();
    test_extreme_settings();
    test_output_hold();
    test_random_settings();
    test_reset_values_again();

    // Drain, then give a stray late beat time to show up
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d ticks (%0d captures, %0d failed decodes), checked %0d result beats",
             ticks_sent, captures_sent, bad_decodes, beats_checked);
    $display("across %0d register settings plus reset values, with a %0d-cycle receiver hold",
             settings_used, HOLD_CYCLES);
    if (fail_count == 0 && pending_sense.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
